// File: rtl/core/assert_macros.svh
// ============================================================================
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("assertion failed");

// When the antecedent holds, the consequent holds in the same cycle.
`define ASSERT_IMPLIES(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// When the antecedent holds, the consequent holds in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: rtl/core/rcmb_pkg.sv
// ============================================================================
// rcmb_pkg
// Types, register codes and arithmetic helpers of the RGB cross mean blur.
// ============================================================================
package rcmb_pkg;

	// Configuration port shape and register indexes.
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 16;
	localparam int CFG_WIDTH_W = 11;
	localparam int HEIGHT_W    = 16;
	localparam int ROW_W       = HEIGHT_W + 1;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_IMAGE_WIDTH  = 2'd0,
		REG_IMAGE_HEIGHT = 2'd1
	} reg_index_t;

	// Sum of five 8-bit channel values.
	localparam int SUM_W = 11;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pixel_t;

	// One line store entry: the row above and the current middle row.
	typedef struct packed {
		pixel_t upper;
		pixel_t middle;
	} line_word_t;

	typedef struct packed {
		logic [SUM_W-1:0] red;
		logic [SUM_W-1:0] green;
		logic [SUM_W-1:0] blue;
	} chan_sum_t;

	// Per-item flags that travel down the pipeline.
	typedef struct packed {
		logic result;
		logic mean;
		logic last;
	} item_flags_t;

	function automatic logic [SUM_W-1:0] sum5(input logic [7:0] a, input logic [7:0] b,
			input logic [7:0] c, input logic [7:0] d, input logic [7:0] e);
		sum5 = SUM_W'(a) + SUM_W'(b) + SUM_W'(c) + SUM_W'(d) + SUM_W'(e);
	endfunction

	// Floor of s / 5 for s up to 1275: multiply by ceil(2^16 / 5) and shift.
	function automatic logic [7:0] div5(input logic [SUM_W-1:0] s);
		logic [24:0] prod;
		prod = 25'(s) * 25'd13108;
		div5 = prod[23:16];
	endfunction

endpackage

// File: rtl/core/rgb_cross_mean_blur.sv
// ============================================================================
// rgb_cross_mean_blur
// Five-point cross mean filter on a raster RGB pixel stream, border copied.
// ============================================================================
//
//  Channel  Direction  Handshake                      Contents
//  s_axis   in         s_axis_tvalid / s_axis_tready  pixel, flush flag in tuser
//  m_axis   out        m_axis_tvalid / m_axis_tready  pixel, frame end in tlast
//  cfg      in         cfg_valid / cfg_ready          register index and data
//
//  One transaction per clock is accepted. An accepted pixel passes the stage-one
//  and stage-two registers into the output register; results lag the input by
//  one line plus one pixel. The line store is a single memory read and written
//  once per clock at the column address, with a forwarding path for its read.
//  Reset clears positions and handshake state; the line store is not cleared.
//  A two-entry output (register plus skid) keeps s_axis_tready registered; the
//  input stalls only while the skid entry holds a result.
//
`include "assert_macros.svh"

module rgb_cross_mean_blur #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [23:0]                      s_axis_tdata,  // in_red, in_green, in_blue
	input  logic                             s_axis_tuser,  // flush
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [23:0]                      m_axis_tdata,  // out_red, out_green, out_blue
	output logic                             m_axis_tlast,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [rcmb_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [rcmb_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int ICW       = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int RST_WIDTH = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
	localparam int ROW_W     = rcmb_pkg::ROW_W;

	// Configuration and input position.
	logic [ICW-1:0]                    width_m1_q;
	logic [rcmb_pkg::HEIGHT_W-1:0]     height_q;
	logic [ICW-1:0]                    ic_q;
	logic [ROW_W-1:0]                  ir_q;

	// Pipeline state.
	logic                              en;
	logic                              fire;
	logic                              step;
	logic                              drain;
	logic [ROW_W-1:0]                  height_ext;
	rcmb_pkg::item_flags_t             flags_now;
	rcmb_pkg::pixel_t                  pix_now;
	logic [ICW-1:0]                    ic_next;
	logic [ROW_W-1:0]                  ir_next;
	logic [ICW-1:0]                    cfg_wm1;
	logic [rcmb_pkg::HEIGHT_W-1:0]     cfg_h;
	logic [rcmb_pkg::CFG_WIDTH_W-1:0]  cfg_w;
	logic                              cfg_fire;

	rcmb_pkg::line_word_t              line_mem [MAX_WIDTH];
	rcmb_pkg::line_word_t              rd_q;

	logic                              valid_s1;
	rcmb_pkg::item_flags_t             flags_s1;
	logic [ICW-1:0]                    ic_s1;
	rcmb_pkg::pixel_t                  pix_s1;
	logic                              fwd_s1;
	rcmb_pkg::line_word_t              fwd_word_s1;

	rcmb_pkg::line_word_t              old_word;
	rcmb_pkg::line_word_t              wr_word;
	rcmb_pkg::pixel_t                  win_a_q;
	rcmb_pkg::pixel_t                  win_b_q;
	rcmb_pkg::pixel_t                  up_q;
	rcmb_pkg::pixel_t                  down_q;
	rcmb_pkg::chan_sum_t               sum_now;

	logic                              valid_s2;
	rcmb_pkg::item_flags_t             flags_s2;
	rcmb_pkg::chan_sum_t               sum_s2;
	rcmb_pkg::pixel_t                  center_s2;
	rcmb_pkg::pixel_t                  result_s2;
	logic                              push;

	logic                              out_valid_q;
	rcmb_pkg::pixel_t                  out_pix_q;
	logic                              out_last_q;
	logic                              skid_valid_q;
	rcmb_pkg::pixel_t                  skid_pix_q;
	logic                              skid_last_q;
	logic                              take;

	// Handshakes: the pipeline runs unless the skid entry is occupied.
	assign en            = !skid_valid_q;
	assign s_axis_tready = en;
	assign cfg_ready     = 1'b1;
	assign cfg_fire      = cfg_valid && cfg_ready;
	assign fire          = s_axis_tvalid && s_axis_tready;
	assign take          = m_axis_tvalid && m_axis_tready;

	// Clamp register writes to the supported ranges.
	always_comb begin
		cfg_w = cfg_data[rcmb_pkg::CFG_WIDTH_W-1:0];
		if (cfg_w < 11'd3) begin
			cfg_wm1 = ICW'(2);
		end else if (32'(cfg_w) > MAX_WIDTH) begin
			cfg_wm1 = ICW'(MAX_WIDTH - 1);
		end else begin
			cfg_wm1 = ICW'(cfg_w - 11'd1);
		end
		cfg_h = (cfg_data < 16'd3) ? 16'd3 : cfg_data;
	end

	// Input stage: classify the item by its position and advance the position.
	always_comb begin
		height_ext     = {1'b0, height_q};
		drain          = ir_q >= height_ext;
		step           = fire && (drain || !s_axis_tuser);
		pix_now.red    = drain ? 8'd0 : s_axis_tdata[7:0];
		pix_now.green  = drain ? 8'd0 : s_axis_tdata[15:8];
		pix_now.blue   = drain ? 8'd0 : s_axis_tdata[23:16];
		flags_now.result = (ir_q >= ROW_W'(2)) || (ir_q == ROW_W'(1) && ic_q != '0);
		flags_now.mean   = (ic_q >= ICW'(2)) && (ir_q >= ROW_W'(2)) && !drain;
		flags_now.last   = (ic_q == '0) && (ir_q == height_ext + ROW_W'(1));
		if (flags_now.last) begin
			ic_next = '0;
			ir_next = '0;
		end else if (ic_q == width_m1_q) begin
			ic_next = '0;
			ir_next = ir_q + ROW_W'(1);
		end else begin
			ic_next = ic_q + ICW'(1);
			ir_next = ir_q;
		end
	end

	// Registers and input position; any register write restarts the frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_m1_q <= ICW'(RST_WIDTH - 1);
			height_q   <= 16'd480;
			ic_q       <= '0;
			ir_q       <= '0;
		end else if (cfg_fire) begin
			unique case (cfg_index)
				rcmb_pkg::REG_IMAGE_WIDTH: begin
					width_m1_q <= cfg_wm1;
					ic_q       <= '0;
					ir_q       <= '0;
				end
				rcmb_pkg::REG_IMAGE_HEIGHT: begin
					height_q <= cfg_h;
					ic_q     <= '0;
					ir_q     <= '0;
				end
				default: begin
				end
			endcase
		end else if (step) begin
			ic_q <= ic_next;
			ir_q <= ir_next;
		end
	end

	// Line store: read at acceptance, written back when the item leaves stage one.
	always_ff @(posedge clk) begin
		if (en && valid_s1) begin
			line_mem[ic_s1] <= wr_word;
		end
		if (step) begin
			rd_q <= line_mem[ic_q];
		end
	end

	// Stage one: pick forwarded data, shift the window, form the channel sums.
	always_comb begin
		old_word       = fwd_s1 ? fwd_word_s1 : rd_q;
		wr_word.upper  = old_word.middle;
		wr_word.middle = pix_s1;
		sum_now.red    = rcmb_pkg::sum5(win_b_q.red, up_q.red, down_q.red,
			win_a_q.red, old_word.middle.red);
		sum_now.green  = rcmb_pkg::sum5(win_b_q.green, up_q.green, down_q.green,
			win_a_q.green, old_word.middle.green);
		sum_now.blue   = rcmb_pkg::sum5(win_b_q.blue, up_q.blue, down_q.blue,
			win_a_q.blue, old_word.middle.blue);
	end

	// Pipeline control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			fwd_s1   <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= step;
			fwd_s1   <= step && valid_s1 && (ic_s1 == ic_q);
			valid_s2 <= valid_s1 && flags_s1.result;
		end
	end

	// Pipeline payload and window state.
	always_ff @(posedge clk) begin
		if (en) begin
			flags_s1    <= flags_now;
			ic_s1       <= ic_q;
			pix_s1      <= pix_now;
			fwd_word_s1 <= wr_word;
			flags_s2    <= flags_s1;
			sum_s2      <= sum_now;
			center_s2   <= win_b_q;
			if (valid_s1) begin
				win_a_q <= win_b_q;
				win_b_q <= old_word.middle;
				up_q    <= old_word.upper;
				down_q  <= pix_s1;
			end
		end
	end

	// Stage two: mean of the cross or the copied border pixel.
	always_comb begin
		if (flags_s2.mean) begin
			result_s2.red   = rcmb_pkg::div5(sum_s2.red);
			result_s2.green = rcmb_pkg::div5(sum_s2.green);
			result_s2.blue  = rcmb_pkg::div5(sum_s2.blue);
		end else begin
			result_s2 = center_s2;
		end
		push = en && valid_s2;
	end

	// Output register with a skid entry behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (take) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			if (!out_valid_q) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			if (skid_valid_q) begin
				out_pix_q  <= skid_pix_q;
				out_last_q <= skid_last_q;
			end else begin
				out_pix_q  <= result_s2;
				out_last_q <= flags_s2.last;
			end
		end else if (push) begin
			if (!out_valid_q) begin
				out_pix_q  <= result_s2;
				out_last_q <= flags_s2.last;
			end else begin
				skid_pix_q  <= result_s2;
				skid_last_q <= flags_s2.last;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_pix_q.blue, out_pix_q.green, out_pix_q.red};
	assign m_axis_tlast  = out_last_q;

	// Checks on the pipeline and position logic.
	`ASSERT_ALWAYS(a_skid_behind_out, !skid_valid_q || out_valid_q)
	`ASSERT_ALWAYS(a_row_in_range, ir_q <= height_ext + ROW_W'(1))
	`ASSERT_IMPLIES(a_fwd_needs_item, fwd_s1, valid_s1)
	`ASSERT_NEXT(a_last_restarts, step && flags_now.last && !cfg_fire, ic_q == '0 && ir_q == '0)

endmodule
